>>> hdl/mhpq_pkg.sv
// mhpq_pkg: shared types and constants of the min-heap priority queue.
// No dependencies.
package mhpq_pkg;
  localparam int HEAP_DEPTH = 4096;
  localparam int IDX_W = $clog2(HEAP_DEPTH);
  localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int KEY_W = 16;
  localparam int POS_W = 6;
  localparam int PAY_W = 32;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_POP = 2'd1;
  localparam logic [1:0] ACT_PEEK = 2'd2;
  localparam logic [1:0] ACT_DECREASE = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [PAY_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;
endpackage

>>> hdl/mhpq_ram.sv
// mhpq_ram: single-write, single-read heap store with registered read data.
// Depends on mhpq_pkg.
module mhpq_ram (
  input  logic                clk,
  input  mhpq_pkg::mem_req_t  req,
  output mhpq_pkg::entry_t    rdata
);
  import mhpq_pkg::*;
  entry_t mem [HEAP_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule

>>> hdl/mhpq_ctrl.sv
// mhpq_ctrl: sequencer for insert, pop, peek, decrease search and sifting.
// Depends on mhpq_pkg; drives the mhpq_ram request.
module mhpq_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              action,
  input  mhpq_pkg::entry_t        in_entry,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              status,
  output mhpq_pkg::entry_t        out_entry,
  output logic [11:0]             found_index,
  output logic                    key_lowered,
  output logic [12:0]             entry_count,
  output mhpq_pkg::mem_req_t      req,
  input  mhpq_pkg::entry_t        rdata
);
  import mhpq_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ROOT = 4'd1;   // root read in flight
  localparam logic [3:0] S_LAST = 4'd2;   // last entry read in flight (pop)
  localparam logic [3:0] S_UPCMP = 4'd3;  // parent data here, next parent read issued
  localparam logic [3:0] S_WCUR = 4'd4;   // climbed to the root, write entry there
  localparam logic [3:0] S_DCHK = 4'd5;   // decrease: parent read issued
  localparam logic [3:0] S_DNL = 4'd6;    // left child read issued, or entry written if none
  localparam logic [3:0] S_DNR = 4'd7;    // right child read issued
  localparam logic [3:0] S_DNCMP = 4'd8;
  localparam logic [3:0] S_SRCH = 4'd9;   // scan, one slot a cycle
  localparam logic [3:0] S_OUT = 4'd10;

  logic [3:0]       state;
  logic [CNT_W-1:0] fill;
  logic [1:0]       act;
  entry_t           cur;      // entry being sifted; its slot is a hole in the store
  logic [CNT_W-1:0] pos;      // the hole's slot
  entry_t           lch;
  logic [CNT_W-1:0] scan;     // next slot issued to the read port
  logic             up_first; // decrease: no climb yet, fall back to sinking

  logic [1:0]       r_status;
  entry_t           r_entry;
  logic [IDX_W-1:0] r_found;
  logic             r_low;
  logic [CNT_W-1:0] r_count;

  logic [CNT_W:0]   left_w, right_w, pick_idx;
  logic [IDX_W-1:0] parent_w, data_idx;
  logic             right_ok, take_right, move_up, move_down, load_out;
  entry_t           pick_entry;

  assign in_stall = (state != S_IDLE);
  assign left_w = {pos, 1'b1};
  assign right_w = left_w + {{CNT_W{1'b0}}, 1'b1};
  assign parent_w = IDX_W'((pos - 1'b1) >> 1);
  assign data_idx = IDX_W'(scan - 1'b1);
  assign right_ok = (right_w < {1'b0, fill});
  assign take_right = right_ok && (rdata.key < lch.key);
  assign pick_entry = take_right ? rdata : lch;
  assign pick_idx = take_right ? right_w : left_w;
  assign move_up = (rdata.key > cur.key);
  assign move_down = (cur.key > pick_entry.key);
  assign load_out = (state == S_OUT) && (!out_valid || !out_stall);

  always_comb begin
    req = '0;
    case (state)
      S_IDLE: begin
        // pop, peek and decrease all start with slot 0
        if (in_valid && action == ACT_INSERT) begin
          if (fill == '0) begin
            req.we = 1'b1;
            req.waddr = '0;
            req.wdata = in_entry;
          end else begin
            req.raddr = IDX_W'((fill - 1'b1) >> 1);
          end
        end
      end
      S_ROOT: req.raddr = IDX_W'(fill - 1'b1);
      S_UPCMP: begin
        req.raddr = IDX_W'((parent_w - 1'b1) >> 1);
        if (move_up) begin
          req.we = 1'b1;
          req.waddr = IDX_W'(pos);
          req.wdata = rdata;
        end else if (!up_first) begin
          req.we = 1'b1;
          req.waddr = IDX_W'(pos);
          req.wdata = cur;
        end
      end
      S_WCUR: begin
        req.we = 1'b1;
        req.waddr = IDX_W'(pos);
        req.wdata = cur;
      end
      S_DCHK: req.raddr = parent_w;
      S_DNL: begin
        if (left_w >= {1'b0, fill}) begin
          req.we = 1'b1;
          req.waddr = IDX_W'(pos);
          req.wdata = cur;
        end else begin
          req.raddr = IDX_W'(left_w);
        end
      end
      S_DNR: req.raddr = IDX_W'(right_w);
      S_DNCMP: begin
        req.we = 1'b1;
        req.waddr = IDX_W'(pos);
        req.wdata = move_down ? pick_entry : cur;
      end
      S_SRCH: req.raddr = IDX_W'(scan);
      default: req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            act <= action;
            cur <= in_entry;
            r_entry <= '0;
            r_found <= '0;
            r_low <= 1'b0;
            case (action)
              ACT_INSERT: begin
                up_first <= 1'b0;
                if (fill >= CNT_W'(HEAP_DEPTH)) begin
                  r_status <= ST_FULL;
                  r_count <= fill;
                  state <= S_OUT;
                end else begin
                  r_status <= ST_DONE;
                  r_count <= fill + 1'b1;
                  pos <= fill;
                  fill <= fill + 1'b1;
                  state <= (fill == '0) ? S_OUT : S_UPCMP;
                end
              end
              ACT_POP, ACT_PEEK: begin
                r_count <= fill;
                if (fill == '0) begin
                  r_status <= ST_EMPTY;
                  state <= S_OUT;
                end else begin
                  r_status <= ST_DONE;
                  state <= S_ROOT;
                end
              end
              default: begin
                r_count <= fill;
                scan <= CNT_W'(1);
                if (fill == '0) begin
                  r_status <= ST_NOT_FOUND;
                  state <= S_OUT;
                end else begin
                  r_status <= ST_DONE;
                  state <= S_SRCH;
                end
              end
            endcase
          end
        end
        S_ROOT: begin
          r_entry <= rdata;
          if (act == ACT_PEEK) begin
            state <= S_OUT;
          end else begin
            fill <= fill - 1'b1;
            r_count <= fill - 1'b1;
            state <= (fill == CNT_W'(1)) ? S_OUT : S_LAST;
          end
        end
        S_LAST: begin
          cur <= rdata;
          pos <= '0;
          state <= S_DNL;
        end
        S_UPCMP: begin
          if (move_up) begin
            pos <= CNT_W'(parent_w);
            up_first <= 1'b0;
            state <= (parent_w == '0) ? S_WCUR : S_UPCMP;
          end else if (up_first) begin
            up_first <= 1'b0;
            state <= S_DNL;
          end else begin
            state <= S_OUT;
          end
        end
        S_WCUR: state <= S_OUT;
        S_DCHK: state <= S_UPCMP;
        S_DNL: state <= (left_w >= {1'b0, fill}) ? S_OUT : S_DNR;
        S_DNR: begin
          lch <= rdata;
          state <= S_DNCMP;
        end
        S_DNCMP: begin
          if (move_down) begin
            pos <= CNT_W'(pick_idx);
            state <= S_DNL;
          end else begin
            state <= S_OUT;
          end
        end
        S_SRCH: begin
          if (rdata.x == cur.x && rdata.y == cur.y) begin
            r_found <= data_idx;
            if (rdata.key > cur.key) begin
              r_low <= 1'b1;
              pos <= CNT_W'(data_idx);
              if (data_idx == '0) begin
                state <= S_DNL;
              end else begin
                up_first <= 1'b1;
                state <= S_DCHK;
              end
            end else begin
              state <= S_OUT;
            end
          end else if (scan >= fill) begin
            r_status <= ST_NOT_FOUND;
            state <= S_OUT;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_OUT: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register: holds the last result while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status <= r_status;
      out_entry <= r_entry;
      found_index <= r_found;
      key_lowered <= r_low;
      entry_count <= r_count;
    end
  end
endmodule

>>> hdl/min_heap_priority_queue_top.sv
// min_heap_priority_queue_top: top level of the min-heap priority queue.
// Depends on mhpq_pkg, mhpq_ctrl and mhpq_ram.
// One item at a time: the input stalls from the accepting edge until the
// result has been moved to the output register. Insert climbs one level
// at a time; peek reads the root; pop descends one level at a time with a
// left read, a right read and a compare through the single read port of
// the store; decrease scans one slot a cycle, and a lowered key below the
// root adds one parent check and then sifts as above. A result held by a
// stalled receiver delays the next result, not the next accept. No clearing
// pass: data read from slots at or above the fill count is never used.
module min_heap_priority_queue_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [15:0] key,
  input  logic [5:0]  pos_x,
  input  logic [5:0]  pos_y,
  input  logic [31:0] payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] out_key,
  output logic [5:0]  out_x,
  output logic [5:0]  out_y,
  output logic [31:0] out_payload,
  output logic [11:0] found_index,
  output logic        key_lowered,
  output logic [12:0] entry_count
);
  import mhpq_pkg::*;
  entry_t   in_entry, out_entry, rdata;
  mem_req_t req;

  assign in_entry = '{key: key, x: pos_x, y: pos_y, payload: payload};
  assign out_key = out_entry.key;
  assign out_x = out_entry.x;
  assign out_y = out_entry.y;
  assign out_payload = out_entry.payload;

  mhpq_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .action, .in_entry,
    .out_valid, .out_stall, .status, .out_entry, .found_index,
    .key_lowered, .entry_count, .req, .rdata
  );
  mhpq_ram u_ram (.clk, .req, .rdata);
endmodule

>>> hdl/mhpq_checker.sv
// mhpq_checker: port-level assertions for the heap queue top level.
// Bound to min_heap_priority_queue_top; no package use.
module mhpq_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic        key_lowered,
  input logic [12:0] entry_count
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(entry_count))
    else $error("result changed under stall");
  a_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_lowered |-> status == 2'd0)
    else $error("lowered with bad status");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= 13'd4096)
    else $error("count out of range");
endmodule

bind min_heap_priority_queue_top mhpq_checker u_chk (
  .clk, .rst, .out_valid, .out_stall, .status, .key_lowered, .entry_count
);

>>> bench/min_heap_priority_queue_top_tb.sv
// min_heap_priority_queue_top_tb: self-checking bench for the min-heap priority queue.
// Depends on mhpq_pkg and min_heap_priority_queue_top; predicts every result with its own heap.
module min_heap_priority_queue_top_tb;
  import mhpq_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] key;
    logic [5:0]  x;
    logic [5:0]  y;
    logic [31:0] payload;
    logic [11:0] found_index;
    logic        key_lowered;
    logic [12:0] entry_count;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = ACT_PEEK;
  logic [15:0] key = '0;
  logic [5:0]  pos_x = '0;
  logic [5:0]  pos_y = '0;
  logic [31:0] payload = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [15:0] out_key;
  logic [5:0]  out_x;
  logic [5:0]  out_y;
  logic [31:0] out_payload;
  logic [11:0] found_index;
  logic        key_lowered;
  logic [12:0] entry_count;

  // shadow heap, kept in step with every accepted item
  entry_t      shadow_heap [HEAP_DEPTH];
  int unsigned shadow_fill = 0;
  answer_t     pending_answers [$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          send_gaps = 1'b1;   // sender idles between items
  bit          recv_gaps = 1'b1;   // receiver stalls before each item
  int unsigned hold_off = 0;       // one long receiver stall, in cycles

  min_heap_priority_queue_top DUT (.*);

  always #5 clk = ~clk;

  // run limit: reaching it means the block hung
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // counts the long receiver stall down
  always @(negedge clk) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (got !== want) begin
      errors++;
      $display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want, cycles);
    end
  endtask

  // ---------------- heap predictor ----------------
  function automatic void swap_shadow(input int unsigned a, input int unsigned b);
    entry_t t;
    t = shadow_heap[a];
    shadow_heap[a] = shadow_heap[b];
    shadow_heap[b] = t;
  endfunction

  function automatic void climb(input int unsigned i);
    int unsigned up;
    while (i > 0) begin
      up = (i - 1) / 2;
      if (shadow_heap[i].key < shadow_heap[up].key) begin
        swap_shadow(i, up);
        i = up;
      end else break;
    end
  endfunction

  function automatic void sink(input int unsigned i);
    int unsigned lc, pick;
    while (2 * i + 1 < shadow_fill) begin
      lc = 2 * i + 1;
      pick = lc;
      // right child only on strictly smaller key
      if (lc + 1 < shadow_fill && shadow_heap[lc + 1].key < shadow_heap[lc].key) pick = lc + 1;
      if (shadow_heap[i].key > shadow_heap[pick].key) begin
        swap_shadow(i, pick);
        i = pick;
      end else break;
    end
  endfunction

  function automatic answer_t apply_action(input logic [1:0] act, input entry_t e);
    answer_t a;
    int unsigned i;
    bit hit;
    a = '{default: '0};
    case (act)
      ACT_INSERT: begin
        if (shadow_fill >= HEAP_DEPTH) a.status = ST_FULL;
        else begin
          shadow_heap[shadow_fill] = e;
          shadow_fill++;
          climb(shadow_fill - 1);
        end
      end
      ACT_POP, ACT_PEEK: begin
        if (shadow_fill == 0) a.status = ST_EMPTY;
        else begin
          a.key = shadow_heap[0].key;
          a.x = shadow_heap[0].x;
          a.y = shadow_heap[0].y;
          a.payload = shadow_heap[0].payload;
          if (act == ACT_POP) begin
            shadow_fill--;
            shadow_heap[0] = shadow_heap[shadow_fill];
            sink(0);
          end
        end
      end
      default: begin
        hit = 1'b0;
        for (i = 0; i < shadow_fill; i++)
          if (shadow_heap[i].x == e.x && shadow_heap[i].y == e.y) begin
            hit = 1'b1;
            break;
          end
        if (!hit) a.status = ST_NOT_FOUND;
        else begin
          a.found_index = i[11:0];
          if (shadow_heap[i].key > e.key) begin
            a.key_lowered = 1'b1;
            shadow_heap[i] = e;
            if (i > 0 && e.key < shadow_heap[(i - 1) / 2].key) climb(i);
            else sink(i);
          end
        end
      end
    endcase
    a.entry_count = shadow_fill[12:0];
    return a;
  endfunction

  // ---------------- sender ----------------
  // Called and left at a falling edge; valid stays high between back-to-back items.
  task automatic send_item(input logic [1:0] act, input logic [15:0] k, input logic [5:0] x,
                           input logic [5:0] y, input logic [31:0] pay);
    int unsigned gap;
    entry_t e;
    answer_t want;
    gap = send_gaps ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    action = act;
    key = k;
    pos_x = x;
    pos_y = y;
    payload = pay;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    e.key = k;
    e.x = x;
    e.y = y;
    e.payload = pay;
    want = apply_action(act, e);
    pending_answers = {pending_answers, want};
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  // ---------------- receiver and checker ----------------
  initial begin
    answer_t want;
    int unsigned w;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      while (hold_off > 0) begin
        out_stall = 1'b1;
        @(negedge clk);
      end
      w = recv_gaps ? $urandom_range(0, 14) : 0;
      if (w > 0) begin
        out_stall = 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      if (pending_answers.size() == 0) begin
        errors++;
        $display("unexpected result item at cycle %0d", cycles);
      end else begin
        want = pending_answers.pop_front();
        report_mismatch("status", status, want.status);
        report_mismatch("out_key", out_key, want.key);
        report_mismatch("out_x", out_x, want.x);
        report_mismatch("out_y", out_y, want.y);
        report_mismatch("out_payload", out_payload, want.payload);
        report_mismatch("found_index", found_index, want.found_index);
        report_mismatch("key_lowered", key_lowered, want.key_lowered);
        report_mismatch("entry_count", entry_count, want.entry_count);
      end
      @(negedge clk);
    end
  end

  // ---------------- tests ----------------
  task automatic test_empty_heap();
    send_item(ACT_POP, 16'h1234, 6'd1, 6'd2, 32'h5);
    send_item(ACT_PEEK, 16'hffff, 6'd63, 6'd63, 32'hffffffff);
    send_item(ACT_DECREASE, 16'h0, 6'd0, 6'd0, 32'h0);
  endtask

  task automatic test_directed();
    send_item(ACT_INSERT, 16'hffff, 6'd63, 6'd63, 32'hffffffff);
    send_item(ACT_INSERT, 16'h0010, 6'd0, 6'd0, 32'h0);
    send_item(ACT_INSERT, 16'h0010, 6'd5, 6'd9, 32'haaaa5555);  // equal key, no climb
    send_item(ACT_INSERT, 16'h8000, 6'd42, 6'd21, 32'h5555aaaa);
    send_item(ACT_INSERT, 16'h0000, 6'd21, 6'd42, 32'h80000001);
    send_item(ACT_PEEK, 16'h0, 6'd0, 6'd0, 32'h0);
    send_item(ACT_DECREASE, 16'h0001, 6'd63, 6'd63, 32'h12345678); // lowered, climbs
    send_item(ACT_DECREASE, 16'h9000, 6'd42, 6'd21, 32'h1);     // not smaller
    send_item(ACT_DECREASE, 16'h0010, 6'd5, 6'd9, 32'h2);       // equal, unchanged
    send_item(ACT_DECREASE, 16'h0000, 6'd7, 6'd7, 32'h3);       // not found
    send_item(ACT_INSERT, 16'h7fff, 6'd42, 6'd21, 32'hdeadbeef); // duplicate position
    send_item(ACT_DECREASE, 16'h0005, 6'd42, 6'd21, 32'h4);     // lowest slot wins
    repeat (8) send_item(ACT_POP, 16'h0, 6'd0, 6'd0, 32'h0);      // runs past empty
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    send_gaps = 1'b0;
    repeat (25) send_item(ACT_INSERT, 16'($urandom), 6'($urandom_range(0, 7)),
                          6'($urandom_range(0, 7)), $urandom);
    send_gaps = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_mix(input int unsigned count);
    int unsigned n, pick, sel;
    logic [1:0] act;
    logic [15:0] k;
    logic [5:0] x, y;
    for (n = 0; n < count; n++) begin
      // alternate stretches with and without idling
      if (n % 100 == 0) begin
        send_gaps = $urandom_range(0, 2) != 0;
        recv_gaps = $urandom_range(0, 2) != 0;
      end
      if (n == count / 2) wait_drained();
      sel = $urandom_range(0, 99);
      if (shadow_fill > 150 && sel < 40) sel = 50;  // keep the heap and scans short
      if (sel < 40) act = ACT_INSERT;
      else if (sel < 65) act = ACT_POP;
      else if (sel < 75) act = ACT_PEEK;
      else act = ACT_DECREASE;
      k = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 15)) : 16'($urandom);
      x = $urandom_range(0, 1) ? 6'($urandom) : 6'($urandom_range(0, 7));
      y = $urandom_range(0, 1) ? 6'($urandom) : 6'($urandom_range(0, 7));
      if (act == ACT_DECREASE && shadow_fill > 0 && $urandom_range(0, 4) != 0) begin
        pick = $urandom_range(0, shadow_fill - 1);
        x = shadow_heap[pick].x;
        y = shadow_heap[pick].y;
        if ($urandom_range(0, 3) != 0) k = 16'($urandom_range(0, shadow_heap[pick].key));
      end
      send_item(act, k, x, y, $urandom);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_heap();
    test_directed();
    test_backpressure();
    test_random_mix(700);
    wait_drained();
    repeat (200) @(negedge clk);
    if (errors == 0 && pending_answers.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

>>> files.f
hdl/mhpq_pkg.sv
hdl/mhpq_ram.sv
hdl/mhpq_ctrl.sv
hdl/min_heap_priority_queue_top.sv
hdl/mhpq_checker.sv
bench/min_heap_priority_queue_top_tb.sv
